FILE: hdl/hsv2rgb_pkg.sv
// shared types and constants for the hsv to rgb converter
package hsv2rgb_pkg;

    localparam int unsigned COMP_W   = 8;
    localparam int unsigned SECTOR_W = 3;
    localparam int unsigned H6_W     = COMP_W + SECTOR_W;
    localparam int unsigned WEIGHT_W = COMP_W + 1;
    localparam int unsigned PROD_W   = 2 * COMP_W;

    typedef logic [COMP_W-1:0]   t_comp;
    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [PROD_W-1:0]   t_prod;

    localparam t_comp HUE_OFFSET_RESET = 8'd170;

    // floor(p / 255) == (p * DIV255_RECIP) >> DIV255_SHIFT for any 16-bit p
    localparam logic [PROD_W-1:0] DIV255_RECIP = 16'h8081;
    localparam int unsigned       DIV255_SHIFT = 23;

    localparam t_weight WEIGHT_ONE = 9'd256;

    // color wheel sectors
    localparam t_sector SECTOR_RED_YEL = 3'd0;
    localparam t_sector SECTOR_YEL_GRN = 3'd1;
    localparam t_sector SECTOR_GRN_CYN = 3'd2;
    localparam t_sector SECTOR_CYN_BLU = 3'd3;
    localparam t_sector SECTOR_BLU_MAG = 3'd4;

endpackage

FILE: hdl/hsv_to_rgb_converter_unit.sv
// hsv to rgb converter: four-stage pipeline, one word per clock when the output is not stalled
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_hue, i_saturation, i_brightness
//  out     | output    | o_out_valid / i_out_ready | o_red, o_green, o_blue
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_data (hue offset)
//
//  a word accepted at the input passes the four register stages in order (hue/product,
//  divide by 255, secondary multiply, sector select and add); throughput is one word per
//  clock when the output is not stalled; each stage holds its word when the stage below
//  is full and not moving, so a stall on the output backs up through the pipeline
//  without loss; bubbles are squeezed out
//  synchronous active-low reset clears all valid bits and loads the hue offset with 170
module hsv_to_rgb_converter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  hsv2rgb_pkg::t_comp  i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hsv2rgb_pkg::t_comp  i_hue,
    input  hsv2rgb_pkg::t_comp  i_saturation,
    input  hsv2rgb_pkg::t_comp  i_brightness,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hsv2rgb_pkg::t_comp  o_red,
    output hsv2rgb_pkg::t_comp  o_green,
    output hsv2rgb_pkg::t_comp  o_blue
);
    import hsv2rgb_pkg::*;

    // hue offset register
    t_comp r_hue_offset;

    // stage enables, computed from the output backwards
    logic en_s1, en_s2, en_s3, en_out;

    // stage 1: rotated hue times six, brightness times saturation
    logic    r_s1_valid;
    t_sector r_s1_sector;
    t_comp   r_s1_frac;
    t_prod   r_s1_prod;
    t_comp   r_s1_val;

    // stage 2: chroma and secondary weight
    logic    r_s2_valid;
    t_comp   r_s2_chroma;
    t_weight r_s2_weight;
    t_sector r_s2_sector;
    t_comp   r_s2_val;

    // stage 3: secondary component and base offset
    logic    r_s3_valid;
    t_comp   r_s3_second;
    t_comp   r_s3_chroma;
    t_comp   r_s3_base;
    t_sector r_s3_sector;

    // output register
    logic    r_out_valid;
    t_comp   r_red, r_green, r_blue;

    // combinational next values
    t_comp             n_rot;
    logic [H6_W-1:0]   n_h6;
    t_prod             n_prod;
    logic [2*PROD_W-1:0] n_recip_prod;
    t_comp             n_chroma;
    t_weight           n_weight;
    logic [COMP_W+WEIGHT_W-1:0] n_sec_prod;
    t_comp             n_second;
    t_comp             n_base;
    t_comp             n_red, n_green, n_blue;

    // a stage moves when its successor is empty or moving too
    assign en_out = !r_out_valid || i_out_ready;
    assign en_s3  = !r_s3_valid  || en_out;
    assign en_s2  = !r_s2_valid  || en_s3;
    assign en_s1  = !r_s1_valid  || en_s2;

    assign o_in_ready  = en_s1;
    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

    // hue offset is written any time the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= HUE_OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_hue_offset <= i_cfg_data;
        end
    end

    // stage 1 logic: rotation wraps at 256, times six by shift and add
    always_comb begin
        n_rot  = i_hue + r_hue_offset;
        n_h6   = {1'b0, n_rot, 2'b00} + {2'b00, n_rot, 1'b0};
        n_prod = {{COMP_W{1'b0}}, i_brightness} * {{COMP_W{1'b0}}, i_saturation};
    end

    // stage 2 logic: divide by 255 via reciprocal; weight falls in odd sectors
    always_comb begin
        n_recip_prod = {{PROD_W{1'b0}}, r_s1_prod} * {{PROD_W{1'b0}}, DIV255_RECIP};
        n_chroma     = n_recip_prod[DIV255_SHIFT +: COMP_W];
        if (r_s1_sector[0]) begin
            n_weight = WEIGHT_ONE - {1'b0, r_s1_frac};
        end else begin
            n_weight = {1'b0, r_s1_frac};
        end
    end

    // stage 3 logic: secondary = chroma * weight / 256, base = value - chroma
    always_comb begin
        n_sec_prod = {{WEIGHT_W{1'b0}}, r_s2_chroma} * {{COMP_W{1'b0}}, r_s2_weight};
        n_second   = n_sec_prod[COMP_W +: COMP_W];
        n_base     = r_s2_val - r_s2_chroma;
    end

    // stage 4 logic: place chroma and secondary by sector, lift by base
    always_comb begin
        case (r_s3_sector)
            SECTOR_RED_YEL: begin
                n_red = r_s3_chroma; n_green = r_s3_second; n_blue = '0;
            end
            SECTOR_YEL_GRN: begin
                n_red = r_s3_second; n_green = r_s3_chroma; n_blue = '0;
            end
            SECTOR_GRN_CYN: begin
                n_red = '0; n_green = r_s3_chroma; n_blue = r_s3_second;
            end
            SECTOR_CYN_BLU: begin
                n_red = '0; n_green = r_s3_second; n_blue = r_s3_chroma;
            end
            SECTOR_BLU_MAG: begin
                n_red = r_s3_second; n_green = '0; n_blue = r_s3_chroma;
            end
            default: begin
                // magenta to red
                n_red = r_s3_chroma; n_green = '0; n_blue = r_s3_second;
            end
        endcase
        n_red   = n_red   + r_s3_base;
        n_green = n_green + r_s3_base;
        n_blue  = n_blue  + r_s3_base;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1)  r_s1_valid  <= i_in_valid;
            if (en_s2)  r_s2_valid  <= r_s1_valid;
            if (en_s3)  r_s3_valid  <= r_s2_valid;
            if (en_out) r_out_valid <= r_s3_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_sector <= n_h6[H6_W-1 -: SECTOR_W];
            r_s1_frac   <= n_h6[COMP_W-1:0];
            r_s1_prod   <= n_prod;
            r_s1_val    <= i_brightness;
        end
        if (en_s2) begin
            r_s2_chroma <= n_chroma;
            r_s2_weight <= n_weight;
            r_s2_sector <= r_s1_sector;
            r_s2_val    <= r_s1_val;
        end
        if (en_s3) begin
            r_s3_second <= n_second;
            r_s3_chroma <= r_s2_chroma;
            r_s3_base   <= n_base;
            r_s3_sector <= r_s2_sector;
        end
        if (en_out) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

endmodule

FILE: bench/hsv_to_rgb_converter_unit_test.sv
// self-checking bench for the hsv to rgb converter: directed table, then random phases
module hsv_to_rgb_converter_unit_test;
    import hsv2rgb_pkg::*;

    // one color word as the block gives it
    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
    } rgb_word_t;

    // one row of the directed table; rgb only counts where typed is set
    typedef struct packed {
        t_comp     hue;
        t_comp     sat;
        t_comp     bright;
        logic      typed;
        rgb_word_t rgb;
    } hsv_row_t;

    localparam int N_DIRECTED      = 21;
    localparam int N_PHASES        = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int DRAIN_CYCLES    = 8;     // extra wait after the last word has left the four-stage pipeline
    localparam int QUIET_LIMIT     = 2000;  // cycles without any word moving

    // directed rows run at the reset hue offset of 170, so hue = rotated hue + 86
    localparam hsv_row_t DIRECTED [N_DIRECTED] = '{
        '{8'd86,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},    // rotated hue 0, pure red
        '{8'd0,   8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},  // zero saturation, grey
        '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},  // zero saturation, white
        '{8'd123, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},    // zero brightness
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},    // all fields low
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},                         // all fields high
        '{8'd85,  8'd255, 8'd255, 1'b0, '0},                         // rotated hue 255
        '{8'd128, 8'd255, 8'd255, 1'b0, '0},                         // last step of red-yellow
        '{8'd129, 8'd255, 8'd255, 1'b0, '0},                         // yellow-green sector
        '{8'd172, 8'd255, 8'd255, 1'b0, '0},                         // green-cyan sector
        '{8'd214, 8'd255, 8'd255, 1'b0, '0},                         // cyan-blue sector
        '{8'd1,   8'd255, 8'd255, 1'b0, '0},                         // blue-magenta sector
        '{8'd44,  8'd255, 8'd255, 1'b0, '0},                         // magenta-red sector
        '{8'd0,   8'd255, 8'd255, 1'b0, '0},                         // offset alone, cyan-blue
        '{8'd170, 8'd255, 8'd128, 1'b0, '0},                         // offset sum wraps
        '{8'd86,  8'd1,   8'd255, 1'b0, '0},
        '{8'd86,  8'd255, 8'd1,   1'b0, '0},
        '{8'd200, 8'd128, 8'd200, 1'b0, '0},
        '{8'h55,  8'hAA,  8'h55,  1'b0, '0},
        '{8'hAA,  8'h55,  8'hAA,  1'b0, '0},
        '{8'd30,  8'd254, 8'd254, 1'b0, '0}
    };

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_comp i_cfg_data;
    logic  i_in_valid;
    logic  o_in_ready;
    t_comp i_hue;
    t_comp i_saturation;
    t_comp i_brightness;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_comp o_red;
    t_comp o_green;
    t_comp o_blue;

    hsv_to_rgb_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    // bench copy of the hue offset register and the colors still owed by the block
    t_comp       hue_offset_shadow;
    rgb_word_t   pending_rgb_q[$];
    rgb_word_t   oldest_rgb;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // sender and receiver idling state
    bit          send_back_to_back;
    int unsigned words_sent;
    bit          recv_free_run;
    int unsigned recv_hold;
    int unsigned recv_cycles;
    int unsigned recv_roll;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hsv to rgb in fixed point: sector and fraction from hue*6, chroma = v*s/255,
    // secondary = chroma*weight/256, then v - chroma lifted onto all three
    function automatic rgb_word_t hsv_to_rgb(t_comp hue, t_comp sat, t_comp bright,
                                             t_comp offset);
        t_comp             rot;
        logic [H6_W-1:0]   h6;
        t_sector           sector;
        t_comp             frac;
        t_prod             prod;
        t_comp             chroma;
        t_weight           weight;
        logic [PROD_W:0]   share;
        t_comp             second;
        t_comp             base;
        rgb_word_t         rgb;
        rot    = hue + offset;                      // wraps modulo 256
        h6     = H6_W'(rot) * H6_W'(6);
        sector = h6[H6_W-1:COMP_W];
        frac   = h6[COMP_W-1:0];
        prod   = t_prod'(bright) * t_prod'(sat);
        chroma = t_comp'(prod / t_prod'(255));
        // rising share in even sectors, falling in odd ones
        weight = sector[0] ? WEIGHT_ONE - t_weight'(frac) : t_weight'(frac);
        share  = (PROD_W+1)'(chroma) * (PROD_W+1)'(weight);
        second = share[COMP_W +: COMP_W];
        base   = bright - chroma;
        case (sector)
            SECTOR_RED_YEL: rgb = '{chroma, second, 8'd0};
            SECTOR_YEL_GRN: rgb = '{second, chroma, 8'd0};
            SECTOR_GRN_CYN: rgb = '{8'd0, chroma, second};
            SECTOR_CYN_BLU: rgb = '{8'd0, second, chroma};
            SECTOR_BLU_MAG: rgb = '{second, 8'd0, chroma};
            default:        rgb = '{chroma, 8'd0, second};
        endcase
        rgb.red   = rgb.red + base;
        rgb.green = rgb.green + base;
        rgb.blue  = rgb.blue + base;
        return rgb;
    endfunction

    // component level biased toward the ends of the range
    function automatic t_comp rand_level();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return t_comp'($urandom_range(0, 255));
    endfunction

    // hand one word to the block, returns at the edge that takes it;
    // valid stays high on return so the next word can follow back to back
    task automatic offer_hsv(t_comp hue, t_comp sat, t_comp bright, rgb_word_t want);
        int unsigned gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (send_back_to_back || roll < 60)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bright;
        pending_rgb_q.push_back(want);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
        // every few dozen words decide whether to run without gaps for a while
        if (words_sent % 48 == 0)
            send_back_to_back = ($urandom_range(0, 3) == 0);
    endtask

    // wait until the pipeline has drained, then write the hue offset
    task automatic load_hue_offset(t_comp value);
        i_in_valid <= 1'b0;
        while (pending_rgb_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hue_offset_shadow = value;
    endtask

    task automatic check_field(string name, t_comp want, t_comp got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // receiver: random stalls, mostly short, a few long, with free-running stretches
    always @(posedge i_clk) begin
        recv_cycles++;
        if (recv_cycles % 64 == 0)
            recv_free_run = ($urandom_range(0, 3) == 0);
        if (recv_hold != 0) begin
            recv_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!recv_free_run) begin
                recv_roll = $urandom_range(0, 99);
                if (recv_roll < 25)
                    recv_hold = $urandom_range(1, 3);
                else if (recv_roll < 29)
                    recv_hold = $urandom_range(10, 40);
            end
        end
    end

    // output checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rgb_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: output word with none expected, r=%0d g=%0d b=%0d",
                         $time, o_red, o_green, o_blue);
            end else begin
                oldest_rgb = pending_rgb_q.pop_front();
                check_field("red",   oldest_rgb.red,   o_red);
                check_field("green", oldest_rgb.green, o_green);
                check_field("blue",  oldest_rgb.blue,  o_blue);
            end
        end
        // any word moving on either side counts as progress
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        rgb_word_t want;
        t_comp     hue;
        t_comp     sat;
        t_comp     bright;
        t_comp     offset;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        words_sent        = 0;
        send_back_to_back = 1'b0;
        recv_free_run     = 1'b0;
        recv_hold         = 0;
        recv_cycles       = 0;
        hue_offset_shadow = HUE_OFFSET_RESET;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset hue offset
        for (int row = 0; row < N_DIRECTED; row++) begin
            if (DIRECTED[row].typed)
                want = DIRECTED[row].rgb;
            else
                want = hsv_to_rgb(DIRECTED[row].hue, DIRECTED[row].sat,
                                  DIRECTED[row].bright, hue_offset_shadow);
            offer_hsv(DIRECTED[row].hue, DIRECTED[row].sat, DIRECTED[row].bright, want);
        end

        // random phases: offsets 0, 255, 1 and the midpoint 128 first, then random ones
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       offset = 8'd0;
                1:       offset = 8'd255;
                2:       offset = 8'd1;
                3:       offset = 8'd128;
                default: offset = t_comp'($urandom_range(0, 255));
            endcase
            load_hue_offset(offset);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                hue    = ($urandom_range(0, 7) == 0) ? rand_level()
                                                     : t_comp'($urandom_range(0, 255));
                sat    = rand_level();
                bright = rand_level();
                offer_hsv(hue, sat, bright, hsv_to_rgb(hue, sat, bright, hue_offset_shadow));
            end
        end

        // drain and report
        i_in_valid <= 1'b0;
        while (pending_rgb_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/hsv2rgb_pkg.sv
hdl/hsv_to_rgb_converter_unit.sv
bench/hsv_to_rgb_converter_unit_test.sv
